>>> hdl/serial_pulse_command_parser_macros.svh
// assertion macros of the serial pulse command parser, used by the pulse timer
`ifndef SERIAL_PULSE_COMMAND_PARSER_MACROS_SVH
`define SERIAL_PULSE_COMMAND_PARSER_MACROS_SVH

// same-cycle implication, checked out of reset
`define SPCP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("spcp assertion failed");

// next-cycle implication, checked out of reset
`define SPCP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("spcp assertion failed");

`endif

>>> hdl/spcp_pkg.sv
// types, character codes and constants of the serial pulse command parser
package spcp_pkg;

    typedef struct packed {
        logic       mode;
        logic [7:0] rx_byte;
    } t_item;

    typedef struct packed {
        logic [7:0] drive_level;
        logic       pulse_event;
    } t_result;

    // command passed from the parser to the pulse timer
    typedef struct packed {
        logic        is_tick;
        logic [7:0]  intensity;
        logic [15:0] duration;
    } t_cmd;

    typedef struct packed {
        logic [15:0] max_duration;
        logic [7:0]  line_limit;
    } t_cfg;

    localparam logic MODE_BYTE = 1'b0;
    localparam logic MODE_TICK = 1'b1;

    localparam logic EVT_START = 1'b0;
    localparam logic EVT_END   = 1'b1;

    localparam logic REG_MAX_DURATION = 1'b0;
    localparam logic REG_LINE_LIMIT   = 1'b1;

    localparam logic [15:0] MAX_DURATION_RESET = 16'd1000;
    localparam logic [7:0]  LINE_LIMIT_RESET   = 8'd63;
    localparam logic [16:0] ACC_MAX            = 17'd131071;
    localparam logic [7:0]  INTENSITY_MAX      = 8'd255;

    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_VT    = 8'h0B;
    localparam logic [7:0] CHAR_FF    = 8'h0C;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_P     = 8'h50;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CHAR_SPACE) || (c == CHAR_TAB) || (c == CHAR_VT) || (c == CHAR_FF);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    endfunction

endpackage

>>> hdl/serial_pulse_command_parser.sv
// top level of the serial pulse command parser: config registers, parser, queue, timer
// The block takes one item (a received byte or a millisecond tick) per clock cycle while full
// is low and gives at most one result per item, in item order, from a one-entry result register.
// Every item runs through the line parser in the cycle it is accepted; ticks and completed
// command lines then enter a QUEUE_DEPTH-entry command queue, and the pulse timer behind
// it retires one command per cycle unless its result must wait for the result register;
// each result passes through the queue and then the result register. full rises only
// when that command queue is full, which happens when results are left waiting on the
// result side, and while it is high every item waits, bytes included. Configuration
// registers: max_duration at byte address 0, line_limit at byte address 4.
module serial_pulse_command_parser #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               push,
    output logic               full,
    input  spcp_pkg::t_item    i_item,
    output logic               empty,
    input  logic               pop,
    output spcp_pkg::t_result  o_result
);
    spcp_pkg::t_cfg  r_cfg;
    logic            cfg_write;
    logic            q_push, q_full, q_pop, q_empty;
    spcp_pkg::t_cmd  q_cmd, q_head;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign full      = q_full;

    always_comb begin
        if (paddr[2] == spcp_pkg::REG_MAX_DURATION) begin
            prdata = {16'd0, r_cfg.max_duration};
        end else begin
            prdata = {24'd0, r_cfg.line_limit};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{max_duration: spcp_pkg::MAX_DURATION_RESET,
                       line_limit:   spcp_pkg::LINE_LIMIT_RESET};
        end else if (cfg_write) begin
            if (paddr[2] == spcp_pkg::REG_MAX_DURATION) begin
                r_cfg.max_duration <= pwdata[15:0];
            end else begin
                r_cfg.line_limit <= pwdata[7:0];
            end
        end
    end

    spcp_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_push   (push),
        .i_item   (i_item),
        .i_q_full (q_full),
        .o_q_push (q_push),
        .o_q_cmd  (q_cmd)
    );

    spcp_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    spcp_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_head  (q_head),
        .o_q_pop   (q_pop),
        .o_empty   (empty),
        .i_pop     (pop),
        .o_result  (o_result)
    );

endmodule

>>> hdl/spcp_fifo.sv
// small command queue between the line parser and the pulse timer
module spcp_fifo #(
    parameter int DEPTH = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  spcp_pkg::t_cmd     i_data,
    output logic               o_full,
    input  logic               i_pop,
    output logic               o_empty,
    output spcp_pkg::t_cmd     o_head
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    spcp_pkg::t_cmd    r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

>>> hdl/spcp_front.sv
// line parser: takes bytes and ticks, turns complete command lines into start commands
module spcp_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  spcp_pkg::t_cfg     i_cfg,
    input  logic               i_push,
    input  spcp_pkg::t_item    i_item,
    input  logic               i_q_full,
    output logic               o_q_push,
    output spcp_pkg::t_cmd     o_q_cmd
);
    typedef enum logic [3:0] {
        PH_LEAD,
        PH_GOT_P,
        PH_HAND,
        PH_INT_WS,
        PH_INT_NUM,
        PH_INT_SKIP,
        PH_DUR_WS,
        PH_DUR_NUM,
        PH_DUR_SKIP
    } t_phase;

    t_phase       r_phase, n_phase;
    logic [7:0]   r_kept, n_kept;
    logic         r_invalid, n_invalid;
    logic [16:0]  r_acc, n_acc;
    logic         r_neg, n_neg;
    logic [7:0]   r_intensity, n_intensity;

    logic         accept;
    logic [7:0]   c;
    logic [20:0]  acc_sum;
    logic [16:0]  digit_acc;
    logic [15:0]  dur_top;
    logic [15:0]  dur;
    logic         line_ok;
    logic         in_int;

    assign accept = i_push && !i_q_full;
    assign c      = i_item.rx_byte;
    assign in_int = (r_phase == PH_INT_WS) || (r_phase == PH_INT_NUM)
                 || (r_phase == PH_INT_SKIP);

    // acc * 10 + digit, saturated
    assign acc_sum   = {1'b0, r_acc, 3'b000} + {3'b000, r_acc, 1'b0} + {17'd0, c[3:0]};
    assign digit_acc = (acc_sum > {4'd0, spcp_pkg::ACC_MAX}) ? spcp_pkg::ACC_MAX
                                                             : acc_sum[16:0];

    assign dur_top = (i_cfg.max_duration == '0) ? 16'd1 : i_cfg.max_duration;
    assign line_ok = !r_invalid && ((r_phase == PH_DUR_WS) || (r_phase == PH_DUR_NUM)
                                 || (r_phase == PH_DUR_SKIP));

    always_comb begin
        if (r_neg || (r_acc == '0)) begin
            dur = 16'd1;
        end else if (r_acc > {1'b0, dur_top}) begin
            dur = dur_top;
        end else begin
            dur = r_acc[15:0];
        end
    end

    always_comb begin
        n_phase     = r_phase;
        n_kept      = r_kept;
        n_invalid   = r_invalid;
        n_acc       = r_acc;
        n_neg       = r_neg;
        n_intensity = r_intensity;
        o_q_push    = 1'b0;
        o_q_cmd     = '{is_tick: 1'b1, intensity: '0, duration: '0};

        if (accept) begin
            if (i_item.mode == spcp_pkg::MODE_TICK) begin
                o_q_push = 1'b1;
            end else if (c == spcp_pkg::CHAR_CR) begin
                // carriage return dropped
            end else if (c == spcp_pkg::CHAR_LF) begin
                n_phase   = PH_LEAD;
                n_kept    = '0;
                n_invalid = 1'b0;
                n_acc     = '0;
                n_neg     = 1'b0;
                if (line_ok) begin
                    o_q_push = 1'b1;
                    o_q_cmd  = '{is_tick: 1'b0, intensity: r_intensity, duration: dur};
                end
            end else if (r_kept < i_cfg.line_limit) begin
                n_kept = r_kept + 1'b1;
                if (!r_invalid) begin
                    if (in_int && (c == spcp_pkg::CHAR_COMMA)) begin
                        // intensity field complete
                        if (r_neg) begin
                            n_intensity = '0;
                        end else if (r_acc > {9'd0, spcp_pkg::INTENSITY_MAX}) begin
                            n_intensity = spcp_pkg::INTENSITY_MAX;
                        end else begin
                            n_intensity = r_acc[7:0];
                        end
                        n_acc   = '0;
                        n_neg   = 1'b0;
                        n_phase = PH_DUR_WS;
                    end else begin
                        case (r_phase)
                            PH_LEAD: begin
                                if (spcp_pkg::is_ws(c)) begin
                                    n_phase = PH_LEAD;
                                end else if (c == spcp_pkg::CHAR_P) begin
                                    n_phase = PH_GOT_P;
                                end else begin
                                    n_invalid = 1'b1;
                                end
                            end
                            PH_GOT_P: begin
                                if (c == spcp_pkg::CHAR_COMMA) begin
                                    n_phase = PH_HAND;
                                end else begin
                                    n_invalid = 1'b1;
                                end
                            end
                            PH_HAND: begin
                                if (c == spcp_pkg::CHAR_COMMA) begin
                                    n_phase = PH_INT_WS;
                                end
                            end
                            PH_INT_WS, PH_DUR_WS: begin
                                if (spcp_pkg::is_ws(c)) begin
                                    n_phase = r_phase;
                                end else if (c == spcp_pkg::CHAR_PLUS) begin
                                    n_phase = in_int ? PH_INT_NUM : PH_DUR_NUM;
                                end else if (c == spcp_pkg::CHAR_MINUS) begin
                                    n_neg   = 1'b1;
                                    n_phase = in_int ? PH_INT_NUM : PH_DUR_NUM;
                                end else if (spcp_pkg::is_digit(c)) begin
                                    n_acc   = digit_acc;
                                    n_phase = in_int ? PH_INT_NUM : PH_DUR_NUM;
                                end else begin
                                    n_phase = in_int ? PH_INT_SKIP : PH_DUR_SKIP;
                                end
                            end
                            PH_INT_NUM, PH_DUR_NUM: begin
                                if (spcp_pkg::is_digit(c)) begin
                                    n_acc = digit_acc;
                                end else begin
                                    n_phase = in_int ? PH_INT_SKIP : PH_DUR_SKIP;
                                end
                            end
                            default: begin
                                n_phase = r_phase;
                            end
                        endcase
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_LEAD;
            r_kept      <= '0;
            r_invalid   <= 1'b0;
            r_acc       <= '0;
            r_neg       <= 1'b0;
            r_intensity <= '0;
        end else begin
            r_phase     <= n_phase;
            r_kept      <= n_kept;
            r_invalid   <= n_invalid;
            r_acc       <= n_acc;
            r_neg       <= n_neg;
            r_intensity <= n_intensity;
        end
    end

endmodule

>>> hdl/spcp_back.sv
// pulse timer: runs start and tick commands, holds the result register
`include "serial_pulse_command_parser_macros.svh"

module spcp_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_empty,
    input  spcp_pkg::t_cmd     i_q_head,
    output logic               o_q_pop,
    output logic               o_empty,
    input  logic               i_pop,
    output spcp_pkg::t_result  o_result
);
    logic [15:0]        r_remaining, n_remaining;
    logic               r_active, n_active;
    logic               r_out_valid, n_out_valid;
    spcp_pkg::t_result  r_out, n_out;

    logic               out_taken;
    logic               out_space;
    logic               emits;
    logic [15:0]        rem_dec;

    assign out_taken = i_pop && r_out_valid;
    assign out_space = !r_out_valid || i_pop;
    assign rem_dec   = (r_remaining != '0) ? r_remaining - 1'b1 : '0;
    // a tick only produces a result when it ends the pulse
    assign emits     = !i_q_head.is_tick || (r_active && (rem_dec == '0));
    assign o_q_pop   = !i_q_empty && (!emits || out_space);
    assign o_empty   = !r_out_valid;
    assign o_result  = r_out;

    always_comb begin
        n_remaining = r_remaining;
        n_active    = r_active;
        n_out       = r_out;
        n_out_valid = r_out_valid && !out_taken;
        if (o_q_pop) begin
            if (i_q_head.is_tick) begin
                if (r_active) begin
                    n_remaining = rem_dec;
                    if (rem_dec == '0) begin
                        n_active    = 1'b0;
                        n_out       = '{drive_level: '0, pulse_event: spcp_pkg::EVT_END};
                        n_out_valid = 1'b1;
                    end
                end
            end else begin
                n_remaining = i_q_head.duration;
                n_active    = 1'b1;
                n_out       = '{drive_level: i_q_head.intensity,
                                pulse_event: spcp_pkg::EVT_START};
                n_out_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_remaining <= '0;
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_remaining <= n_remaining;
            r_active    <= n_active;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    `SPCP_ASSERT_NOW(a_end_level_zero, i_clk, i_rst_n,
        r_out_valid && (r_out.pulse_event == spcp_pkg::EVT_END), r_out.drive_level == '0)
    `SPCP_ASSERT_NOW(a_active_has_time, i_clk, i_rst_n, r_active, r_remaining != '0)
    `SPCP_ASSERT_NEXT(a_start_arms_timer, i_clk, i_rst_n,
        o_q_pop && !i_q_head.is_tick, r_active && r_out_valid)

endmodule

>>> tb/sv/tb_serial_pulse_command_parser.sv
// self-checking testbench of the serial pulse command parser: scoreboard, drivers, stimulus
typedef enum logic [3:0] {
    LEAD_BLANKS,
    AFTER_P,
    HAND_TEXT,
    LEVEL_BLANKS,
    LEVEL_DIGITS,
    LEVEL_TAIL,
    LENGTH_BLANKS,
    LENGTH_DIGITS,
    LENGTH_TAIL
} t_line_phase;

class t_pulse_scoreboard;
    logic [15:0]       max_duration;
    logic [7:0]        line_limit;
    t_line_phase       phase;
    logic [7:0]        kept;
    bit                spoiled;
    logic [16:0]       acc;
    bit                negative;
    logic [7:0]        held_level;
    logic [15:0]       ms_left;
    bit                pulsing;
    spcp_pkg::t_result expected_pulses[$];
    int                errors;

    function new();
        max_duration = spcp_pkg::MAX_DURATION_RESET;
        line_limit   = spcp_pkg::LINE_LIMIT_RESET;
        held_level   = '0;
        ms_left      = '0;
        pulsing      = 1'b0;
        errors       = 0;
        restart_line();
    endfunction

    function void set_reg(logic idx, logic [31:0] value);
        if (idx == spcp_pkg::REG_MAX_DURATION) begin
            max_duration = value[15:0];
        end else begin
            line_limit = value[7:0];
        end
    endfunction

    function int pending();
        return expected_pulses.size();
    endfunction

    function void restart_line();
        phase    = LEAD_BLANKS;
        kept     = '0;
        spoiled  = 1'b0;
        acc      = '0;
        negative = 1'b0;
    endfunction

    function bit is_blank(logic [7:0] c);
        return c == spcp_pkg::CHAR_SPACE || c == spcp_pkg::CHAR_TAB ||
               c == spcp_pkg::CHAR_VT || c == spcp_pkg::CHAR_FF;
    endfunction

    function bit is_num(logic [7:0] c);
        return c >= spcp_pkg::CHAR_ZERO && c <= spcp_pkg::CHAR_NINE;
    endfunction

    function void add_digit(logic [7:0] c);
        int unsigned t;
        t = acc;
        t = t * 10 + (c - spcp_pkg::CHAR_ZERO);
        acc = (t > spcp_pkg::ACC_MAX) ? spcp_pkg::ACC_MAX : t[16:0];
    endfunction

    function t_line_phase number_lead(logic [7:0] c, t_line_phase blanks,
                                      t_line_phase digits, t_line_phase tail);
        if (is_blank(c)) return blanks;
        if (c == spcp_pkg::CHAR_PLUS) return digits;
        if (c == spcp_pkg::CHAR_MINUS) begin
            negative = 1'b1;
            return digits;
        end
        if (is_num(c)) begin
            add_digit(c);
            return digits;
        end
        return tail;
    endfunction

    function void take_char(logic [7:0] c);
        if (spoiled) return;
        case (phase)
            LEAD_BLANKS: begin
                if (!is_blank(c)) begin
                    if (c == spcp_pkg::CHAR_P) phase = AFTER_P;
                    else spoiled = 1'b1;
                end
            end
            AFTER_P: begin
                if (c == spcp_pkg::CHAR_COMMA) phase = HAND_TEXT;
                else spoiled = 1'b1;
            end
            HAND_TEXT: begin
                if (c == spcp_pkg::CHAR_COMMA) phase = LEVEL_BLANKS;
            end
            LEVEL_BLANKS, LEVEL_DIGITS, LEVEL_TAIL: begin
                if (c == spcp_pkg::CHAR_COMMA) begin
                    if (negative) held_level = '0;
                    else if (acc > 17'(spcp_pkg::INTENSITY_MAX))
                        held_level = spcp_pkg::INTENSITY_MAX;
                    else held_level = acc[7:0];
                    acc      = '0;
                    negative = 1'b0;
                    phase    = LENGTH_BLANKS;
                end else if (phase == LEVEL_BLANKS) begin
                    phase = number_lead(c, LEVEL_BLANKS, LEVEL_DIGITS, LEVEL_TAIL);
                end else if (phase == LEVEL_DIGITS) begin
                    if (is_num(c)) add_digit(c);
                    else phase = LEVEL_TAIL;
                end
            end
            LENGTH_BLANKS: begin
                phase = number_lead(c, LENGTH_BLANKS, LENGTH_DIGITS, LENGTH_TAIL);
            end
            LENGTH_DIGITS: begin
                if (is_num(c)) add_digit(c);
                else phase = LENGTH_TAIL;
            end
            default: ;
        endcase
    endfunction

    function void note_request(spcp_pkg::t_item it);
        logic [15:0]       ceiling;
        logic [15:0]       dur;
        bit                good;
        spcp_pkg::t_result r;
        if (it.mode == spcp_pkg::MODE_TICK) begin
            if (!pulsing) return;
            if (ms_left != 0) ms_left = ms_left - 1'b1;
            if (ms_left != 0) return;
            pulsing       = 1'b0;
            r.drive_level = '0;
            r.pulse_event = spcp_pkg::EVT_END;
            expected_pulses.push_back(r);
            return;
        end
        if (it.rx_byte == spcp_pkg::CHAR_CR) return;
        if (it.rx_byte != spcp_pkg::CHAR_LF) begin
            if (kept < line_limit) begin
                kept = kept + 1'b1;
                take_char(it.rx_byte);
            end
            return;
        end
        // newline: judge the line
        good = !spoiled && (phase == LENGTH_BLANKS || phase == LENGTH_DIGITS ||
                            phase == LENGTH_TAIL);
        ceiling = (max_duration == 0) ? 16'd1 : max_duration;
        if (negative || acc == 0) dur = 16'd1;
        else if (acc > 17'(ceiling)) dur = ceiling;
        else dur = acc[15:0];
        restart_line();
        if (!good) return;
        ms_left       = dur;
        pulsing       = 1'b1;
        r.drive_level = held_level;
        r.pulse_event = spcp_pkg::EVT_START;
        expected_pulses.push_back(r);
    endfunction

    function void check_result(spcp_pkg::t_result got);
        spcp_pkg::t_result want;
        if (expected_pulses.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none, actual level %0d event %0d",
                     $time, got.drive_level, got.pulse_event);
            return;
        end
        want = expected_pulses.pop_front();
        if (got.drive_level !== want.drive_level) begin
            errors++;
            $display("%0t: drive_level expected %0d actual %0d",
                     $time, want.drive_level, got.drive_level);
        end
        if (got.pulse_event !== want.pulse_event) begin
            errors++;
            $display("%0t: pulse_event expected %0d actual %0d",
                     $time, want.pulse_event, got.pulse_event);
        end
    endfunction
endclass

module tb_serial_pulse_command_parser;

    localparam int PHASES      = 8;
    localparam int DRAIN       = 12;
    localparam int STUCK_LIMIT = 2000;
    localparam logic [7:0] LOWER_A = 8'h61;

    localparam int unsigned CAP_TABLE [PHASES]    = '{1000, 0, 65535, 1, 30, 1000, 0, 1000};
    localparam int unsigned LIMIT_TABLE [PHASES]  = '{63, 63, 255, 5, 0, 1, 0, 63};
    localparam int unsigned BUDGET_TABLE [PHASES] = '{300, 180, 250, 150, 60, 60, 300, 300};
    localparam int unsigned IDLE_TABLE [PHASES]   = '{6, 10, 0, 4, 8, 12, 5, 0};

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [2:0]        paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;
    logic              push = 1'b0;
    logic              full;
    spcp_pkg::t_item   i_item = '0;
    logic              empty;
    logic              pop = 1'b0;
    spcp_pkg::t_result o_result;

    t_pulse_scoreboard sb;
    spcp_pkg::t_item   request_q[$];
    logic [7:0]        line_buf[$];
    int unsigned       idle_den = 0;
    int                stuck_cycles = 0;

    serial_pulse_command_parser dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .push     (push),
        .full     (full),
        .i_item   (i_item),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // accepted requests and results, plus the stall watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (push && !full) sb.note_request(i_item);
            if (pop && !empty) sb.check_result(o_result);
            if ((push && !full) || (pop && !empty)) begin
                stuck_cycles <= 0;
            end else begin
                stuck_cycles <= stuck_cycles + 1;
            end
            if (stuck_cycles >= STUCK_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // result side: pop with random stall bursts
    initial begin
        wait (i_rst_n);
        forever begin
            if (idle_den != 0 && $urandom_range(0, 2 * idle_den - 1) == 0) begin
                pop <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge i_clk);
            end
            pop <= 1'b1;
            @(posedge i_clk);
        end
    end

    function automatic void put_byte(logic [7:0] b);
        spcp_pkg::t_item it;
        it.mode    = spcp_pkg::MODE_BYTE;
        it.rx_byte = b;
        request_q.push_back(it);
    endfunction

    function automatic void put_tick();
        spcp_pkg::t_item it;
        it.mode    = spcp_pkg::MODE_TICK;
        it.rx_byte = 8'($urandom_range(0, 255));
        request_q.push_back(it);
    endfunction

    function automatic void put_text(string s);
        foreach (s[i]) put_byte(s[i]);
    endfunction

    function automatic logic [7:0] blank_pick();
        case ($urandom_range(0, 3))
            0: return spcp_pkg::CHAR_SPACE;
            1: return spcp_pkg::CHAR_TAB;
            2: return spcp_pkg::CHAR_VT;
            default: return spcp_pkg::CHAR_FF;
        endcase
    endfunction

    function automatic logic [7:0] hand_char();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255));
        while (c == spcp_pkg::CHAR_COMMA || c == spcp_pkg::CHAR_LF || c == spcp_pkg::CHAR_CR);
        return c;
    endfunction

    function automatic void number_text(bit is_length);
        int unsigned v;
        string       s;
        repeat (($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0)
            line_buf.push_back(blank_pick());
        case ($urandom_range(0, 9))
            0: line_buf.push_back(spcp_pkg::CHAR_PLUS);
            1, 2: line_buf.push_back(spcp_pkg::CHAR_MINUS);
            default: ;
        endcase
        case ($urandom_range(0, 9))
            0: ;
            // long digit runs can push the accumulator into saturation
            1: repeat ($urandom_range(6, 9))
                line_buf.push_back(8'(spcp_pkg::CHAR_ZERO + $urandom_range(0, 9)));
            default: begin
                if (is_length) begin
                    v = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 70000)
                                                    : $urandom_range(0, 25);
                end else begin
                    v = $urandom_range(0, 300);
                end
                s = $sformatf("%0d", v);
                if ($urandom_range(0, 7) == 0) s = {"00", s};
                foreach (s[i]) line_buf.push_back(s[i]);
            end
        endcase
        if ($urandom_range(0, 6) == 0) begin
            line_buf.push_back(($urandom_range(0, 3) == 0) ? spcp_pkg::CHAR_SPACE
                               : 8'(LOWER_A + $urandom_range(0, 25)));
        end
    endfunction

    function automatic void build_command();
        line_buf.delete();
        repeat (($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0)
            line_buf.push_back(blank_pick());
        line_buf.push_back(spcp_pkg::CHAR_P);
        line_buf.push_back(spcp_pkg::CHAR_COMMA);
        repeat (($urandom_range(0, 15) == 0) ? $urandom_range(40, 80) : $urandom_range(0, 3))
            line_buf.push_back(hand_char());
        line_buf.push_back(spcp_pkg::CHAR_COMMA);
        number_text(1'b0);
        line_buf.push_back(spcp_pkg::CHAR_COMMA);
        number_text(1'b1);
    endfunction

    function automatic void emit_line(bit with_lf);
        foreach (line_buf[i]) begin
            if ($urandom_range(0, 19) == 0) put_tick();
            if ($urandom_range(0, 29) == 0) put_byte(spcp_pkg::CHAR_CR);
            put_byte(line_buf[i]);
        end
        if (with_lf) begin
            if ($urandom_range(0, 3) == 0) put_byte(spcp_pkg::CHAR_CR);
            put_byte(spcp_pkg::CHAR_LF);
        end
    endfunction

    function automatic void add_sequence();
        int unsigned pick;
        int          k;
        pick = $urandom_range(0, 9);
        if (pick < 7) begin
            build_command();
            emit_line(1'b1);
        end else if (pick < 9) begin
            // well-formed command with one fault in it
            build_command();
            case ($urandom_range(0, 2))
                0: line_buf[$urandom_range(0, line_buf.size() - 1)] = 8'($urandom_range(0, 255));
                1: line_buf.delete($urandom_range(0, line_buf.size() - 1));
                default: begin
                    k = $urandom_range(0, line_buf.size() - 1);
                    while (line_buf.size() > k) void'(line_buf.pop_back());
                end
            endcase
            emit_line($urandom_range(0, 3) != 0);
        end else begin
            line_buf.delete();
            repeat ($urandom_range(1, 20)) line_buf.push_back(8'($urandom_range(0, 255)));
            emit_line($urandom_range(0, 1) == 1);
        end
        repeat (($urandom_range(0, 4) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 4))
            put_tick();
    endfunction

    task automatic send_request(spcp_pkg::t_item it);
        push   <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (full);
        if (idle_den != 0 && $urandom_range(0, idle_den - 1) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
    endtask

    task automatic send_all();
        foreach (request_q[i]) send_request(request_q[i]);
        if (push) push <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_reg(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // block is idle once every expected pulse is out and its queue has drained
    task automatic wait_idle();
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    initial begin
        int unsigned cap;
        int unsigned lim;
        sb = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // tick while idle, clamped command with cr and extreme bytes, negative level
        request_q.delete();
        put_tick();
        put_text(" P,");
        put_byte(8'hFF);
        put_text(",999,2");
        put_byte(spcp_pkg::CHAR_CR);
        put_byte(spcp_pkg::CHAR_LF);
        put_tick();
        put_tick();
        put_text("P,");
        put_byte(8'h00);
        put_text(",-1,0");
        put_byte(spcp_pkg::CHAR_LF);
        put_tick();
        send_all();

        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph != 0) begin
                cap = CAP_TABLE[ph];
                lim = LIMIT_TABLE[ph];
                if (ph == 6) begin
                    cap = $urandom_range(1, 200);
                    lim = $urandom_range(10, 255);
                end
                wait_idle();
                write_reg(spcp_pkg::REG_MAX_DURATION, cap);
                write_reg(spcp_pkg::REG_LINE_LIMIT, lim);
            end
            idle_den = IDLE_TABLE[ph];
            request_q.delete();
            while (request_q.size() < BUDGET_TABLE[ph]) add_sequence();
            send_all();
        end

        wait_idle();
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+hdl
hdl/spcp_pkg.sv
hdl/spcp_fifo.sv
hdl/spcp_front.sv
hdl/spcp_back.sv
hdl/serial_pulse_command_parser.sv
tb/sv/tb_serial_pulse_command_parser.sv
